// ===== rtl/core/branch_direction_predictor_defines.svh =====
// assertion macros shared by the predictor modules
`ifndef BRANCH_DIRECTION_PREDICTOR_DEFINES_SVH
`define BRANCH_DIRECTION_PREDICTOR_DEFINES_SVH

// condition implies consequence in the same cycle
`define BDP_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// condition implies consequence in the next cycle
`define BDP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/core/bdp_pkg.sv =====
package bdp_pkg;

	localparam int INDEX_BITS_DEF   = 14;
	localparam int HISTORY_BITS_DEF = 16;

	localparam logic [31:0] FIB_MULT = 32'd2654435769;

	typedef logic [2:0] counter_t;

	localparam counter_t CNT_UNTOUCHED  = 3'd0;
	localparam counter_t CNT_MIN        = 3'd1;
	localparam counter_t CNT_WEAK_TAKEN = 3'd3;
	localparam counter_t CNT_MAX        = 3'd4;

	typedef enum logic [1:0] {
		MODE_BIMODAL = 2'd0,
		MODE_GSELECT = 2'd1,
		MODE_GSHARE  = 2'd2,
		MODE_NONE    = 2'd3
	} mode_t;

endpackage

// ===== rtl/core/bdp_index.sv =====
module bdp_index #(
	parameter int INDEX_BITS   = bdp_pkg::INDEX_BITS_DEF,
	parameter int HISTORY_BITS = bdp_pkg::HISTORY_BITS_DEF
) (
	input  logic [31:0]             branch_address,
	input  logic [HISTORY_BITS-1:0] hist,
	input  bdp_pkg::mode_t          mode,
	output logic [INDEX_BITS+1:0]   slot,
	output logic                    use_table
);

	localparam int LOW_BITS = 32 - HISTORY_BITS;
	localparam logic [31:0] ADDR_MASK = (HISTORY_BITS == 32) ? 32'h0 :
		((32'h1 << LOW_BITS) - 32'h1);

	logic [31:0]           hist_ext;
	logic [31:0]           gsel_key;
	logic [31:0]           hash_key;
	logic [31:0]           prod;
	logic [31:0]           share_key;
	logic [INDEX_BITS-1:0] idx;

	assign hist_ext  = 32'(hist);
	assign gsel_key  = (hist_ext << LOW_BITS) | (branch_address & ADDR_MASK);
	assign hash_key  = (mode == bdp_pkg::MODE_GSELECT) ? gsel_key : branch_address;
	// fibonacci hash, top bits of the low product word
	assign prod      = hash_key * bdp_pkg::FIB_MULT;
	assign share_key = branch_address ^ hist_ext;

	always_comb begin
		unique case (mode) inside
			bdp_pkg::MODE_BIMODAL,
			bdp_pkg::MODE_GSELECT: idx = prod[31 -: INDEX_BITS];
			bdp_pkg::MODE_GSHARE:  idx = share_key[INDEX_BITS-1:0];
			default:               idx = '0;
		endcase
	end

	assign slot      = {mode, idx};
	assign use_table = (mode != bdp_pkg::MODE_NONE);

endmodule

// ===== rtl/core/bdp_counter_ram.sv =====
`include "branch_direction_predictor_defines.svh"

module bdp_counter_ram #(
	parameter int INDEX_BITS = bdp_pkg::INDEX_BITS_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   rd_en,
	input  logic [INDEX_BITS+1:0]  rd_addr,
	output bdp_pkg::counter_t      rd_data,
	input  logic                   wr_en,
	input  logic [INDEX_BITS+1:0]  wr_addr,
	input  bdp_pkg::counter_t      wr_data,
	output logic                   clr_busy
);

	localparam int DEPTH     = 3 * (1 << INDEX_BITS);
	localparam int SLOT_BITS = INDEX_BITS + 2;
	localparam logic [SLOT_BITS-1:0] LAST_SLOT = SLOT_BITS'(DEPTH - 1);

	bdp_pkg::counter_t     mem [0:DEPTH-1];
	bdp_pkg::counter_t     rd_data_q;
	logic                  clr_busy_q;
	logic [SLOT_BITS-1:0]  clr_addr_q;
	logic                  mem_we;
	logic [SLOT_BITS-1:0]  mem_waddr;
	bdp_pkg::counter_t     mem_wdata;

	// clearing sweep owns the write port after reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_busy_q <= 1'b1;
			clr_addr_q <= '0;
		end else if (clr_busy_q) begin
			clr_addr_q <= clr_addr_q + SLOT_BITS'(1);
			if (clr_addr_q == LAST_SLOT) begin
				clr_busy_q <= 1'b0;
			end
		end
	end

	assign mem_we    = clr_busy_q | wr_en;
	assign mem_waddr = clr_busy_q ? clr_addr_q : wr_addr;
	assign mem_wdata = clr_busy_q ? bdp_pkg::CNT_UNTOUCHED : wr_data;

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_waddr] <= mem_wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	assign rd_data  = rd_data_q;
	assign clr_busy = clr_busy_q;

	`BDP_ASSERT_SAME(a_no_write_in_clear, clk, arst_n, clr_busy_q, !wr_en, "write during clear")
	`BDP_ASSERT_SAME(a_clear_ends_at_last, clk, arst_n, $fell(clr_busy_q),
		$past(clr_addr_q) == LAST_SLOT, "clear ended early")

endmodule

// ===== rtl/core/branch_direction_predictor.sv =====
// an accepted beat's prediction is written into the result queue driving the outputs
// throughput: one branch per cycle while in_stall is low; counter read, update and
// write back in a two-stage pipeline, registered-read memory, last write forwarded
// reset: asynchronous, active low; history cleared, last prediction taken, mode bimodal
// after reset a clearing pass writes all 3 * 2**INDEX_BITS counters (49152 by
// default), during which in_stall stays high
`include "branch_direction_predictor_defines.svh"

module branch_direction_predictor #(
	parameter int INDEX_BITS   = bdp_pkg::INDEX_BITS_DEF,
	parameter int HISTORY_BITS = bdp_pkg::HISTORY_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_write,
	input  logic [1:0]  cfg_data,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [31:0] branch_address,
	input  logic        taken,
	output logic        out_valid,
	input  logic        out_stall,
	output logic        predict_taken
);

	localparam int SLOT_BITS = INDEX_BITS + 2;

	bdp_pkg::mode_t          mode_q;
	logic [HISTORY_BITS-1:0] hist_q;
	logic                    last_q;

	logic                    accept;
	logic                    pop;
	logic                    clr_busy;
	logic [SLOT_BITS-1:0]    slot;
	logic                    use_table;

	logic                    valid_s1;
	logic [SLOT_BITS-1:0]    slot_s1;
	logic                    taken_s1;
	logic                    tbl_s1;

	bdp_pkg::counter_t       rd_data;
	logic                    fwd_en_q;
	logic [SLOT_BITS-1:0]    fwd_slot_q;
	bdp_pkg::counter_t       fwd_data_q;
	bdp_pkg::counter_t       cnt_rd;
	bdp_pkg::counter_t       cnt_eff;
	bdp_pkg::counter_t       cnt_next;
	logic                    untouched;
	logic                    pred_s1;
	logic                    wr_en;

	logic                    q_data_q [0:1];
	logic                    q_wr_ptr_q;
	logic                    q_rd_ptr_q;
	logic [1:0]              q_cnt_q;
	logic [1:0]              occ;

	// handshake and result queue credit
	assign pop      = out_valid & ~out_stall;
	assign occ      = q_cnt_q + 2'(valid_s1);
	assign in_stall = clr_busy | ((occ == 2'd2) & ~pop);
	assign accept   = in_valid & ~in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= bdp_pkg::MODE_BIMODAL;
		end else if (cfg_write) begin
			mode_q <= bdp_pkg::mode_t'(cfg_data);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hist_q <= '0;
		end else if (accept) begin
			hist_q <= HISTORY_BITS'({hist_q, taken});
		end
	end

	bdp_index #(
		.INDEX_BITS   (INDEX_BITS),
		.HISTORY_BITS (HISTORY_BITS)
	) u_index (
		.branch_address (branch_address),
		.hist           (hist_q),
		.mode           (mode_q),
		.slot           (slot),
		.use_table      (use_table)
	);

	bdp_counter_ram #(
		.INDEX_BITS (INDEX_BITS)
	) u_ram (
		.clk      (clk),
		.arst_n   (arst_n),
		.rd_en    (accept & use_table),
		.rd_addr  (slot),
		.rd_data  (rd_data),
		.wr_en    (wr_en),
		.wr_addr  (slot_s1),
		.wr_data  (cnt_next),
		.clr_busy (clr_busy)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			slot_s1  <= slot;
			taken_s1 <= taken;
			tbl_s1   <= use_table;
		end
	end

	// forward the write that landed on the same edge as this read
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fwd_en_q <= 1'b0;
		end else begin
			fwd_en_q <= wr_en;
		end
	end

	always_ff @(posedge clk) begin
		fwd_slot_q <= slot_s1;
		fwd_data_q <= cnt_next;
	end

	assign cnt_rd    = (fwd_en_q && (fwd_slot_q == slot_s1)) ? fwd_data_q : rd_data;
	assign untouched = (cnt_rd == bdp_pkg::CNT_UNTOUCHED);
	assign cnt_eff   = untouched ? bdp_pkg::CNT_WEAK_TAKEN : cnt_rd;
	assign pred_s1   = (!tbl_s1 || untouched) ? last_q :
		(cnt_eff >= bdp_pkg::CNT_WEAK_TAKEN);
	assign wr_en     = valid_s1 & tbl_s1;

	always_comb begin
		if (taken_s1) begin
			cnt_next = (cnt_eff < bdp_pkg::CNT_MAX) ? cnt_eff + 3'd1 : bdp_pkg::CNT_MAX;
		end else begin
			cnt_next = (cnt_eff > bdp_pkg::CNT_MIN) ? cnt_eff - 3'd1 : bdp_pkg::CNT_MIN;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_q <= 1'b1;
		end else if (wr_en) begin
			last_q <= pred_s1;
		end
	end

	// two-beat result queue
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			q_wr_ptr_q <= 1'b0;
			q_rd_ptr_q <= 1'b0;
			q_cnt_q    <= 2'd0;
		end else begin
			if (valid_s1) begin
				q_wr_ptr_q <= ~q_wr_ptr_q;
			end
			if (pop) begin
				q_rd_ptr_q <= ~q_rd_ptr_q;
			end
			q_cnt_q <= q_cnt_q + 2'(valid_s1) - 2'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1) begin
			q_data_q[q_wr_ptr_q] <= pred_s1;
		end
	end

	assign out_valid     = (q_cnt_q != 2'd0);
	assign predict_taken = q_data_q[q_rd_ptr_q];

	`BDP_ASSERT_SAME(a_no_accept_in_clear, clk, arst_n, accept, !clr_busy, "beat taken during clear")
	`BDP_ASSERT_SAME(a_queue_bound, clk, arst_n, 1'b1, occ <= 2'd2, "result queue overrun")
	`BDP_ASSERT_NEXT(a_accept_to_s1, clk, arst_n, accept, valid_s1, "accepted beat lost")
	`BDP_ASSERT_NEXT(a_last_kept_no_table, clk, arst_n, valid_s1 && !tbl_s1,
		$stable(last_q), "last prediction changed without table access")

endmodule
